### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// clocked assertion macros with an active-low reset disable
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/wsb_pkg.sv
// ----------------------------------------------------------------------------
// wsb_pkg
// shared types and constants of the word stream bus bridge
// ----------------------------------------------------------------------------
package wsb_pkg;

    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_READREQ = 2'd1;
    localparam logic [1:0] KIND_TX      = 2'd2;
    localparam logic [1:0] KIND_BAD     = 2'd3;

    localparam logic [15:0] CMD_WRITE = 16'h0001;
    localparam logic [15:0] CMD_READ  = 16'h0002;

    localparam logic [31:0] ADDR_STEP = 32'd4;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [3:0] {
        PH_ADDR  = 4'b0001,
        PH_CTRL  = 4'b0010,
        PH_WRITE = 4'b0100,
        PH_READ  = 4'b1000
    } t_phase;

    // one or two results caused by one input transaction
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [31:0] data;
        logic        has_second;
        logic [31:0] second_address;
    } t_job;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_stat;

endpackage

### rtl/wsb_front.sv
// ----------------------------------------------------------------------------
// wsb_front
// accepts link words and read returns, tracks the transaction phase
// ----------------------------------------------------------------------------
module wsb_front import wsb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [31:0] i_word,
    input  t_q_stat     i_q_stat,
    output logic        o_push,
    output t_job        o_job
);

    t_phase      r_phase, n_phase;
    logic [31:0] r_addr, n_addr;
    logic [15:0] r_count, n_count;
    logic [15:0] r_done, n_done;
    logic [15:0] done_inc;
    logic        job_valid;
    logic        accept;

    assign o_ready  = !i_q_stat.full;
    assign accept   = i_valid && o_ready;
    assign o_push   = accept && job_valid;
    assign done_inc = r_done + 16'd1;

    always_comb begin
        n_phase   = r_phase;
        n_addr    = r_addr;
        n_count   = r_count;
        n_done    = r_done;
        job_valid = 1'b0;
        o_job     = '0;
        case (r_phase)
            PH_ADDR: begin
                if (!i_mode) begin
                    n_addr  = i_word;
                    n_phase = PH_CTRL;
                end
            end
            PH_CTRL: begin
                if (!i_mode) begin
                    if (i_word[15:0] == 16'd0) begin
                        n_phase = PH_ADDR;
                        n_addr  = '0;
                        n_count = '0;
                        n_done  = '0;
                    end else if (i_word[31:16] == CMD_WRITE) begin
                        n_count = i_word[15:0];
                        n_done  = '0;
                        n_phase = PH_WRITE;
                    end else if (i_word[31:16] == CMD_READ) begin
                        n_count       = i_word[15:0];
                        n_done        = '0;
                        n_phase       = PH_READ;
                        n_addr        = r_addr + ADDR_STEP;
                        job_valid     = 1'b1;
                        o_job.kind    = KIND_READREQ;
                        o_job.address = r_addr;
                    end else begin
                        n_phase    = PH_ADDR;
                        n_addr     = '0;
                        n_count    = '0;
                        n_done     = '0;
                        job_valid  = 1'b1;
                        o_job.kind = KIND_BAD;
                    end
                end
            end
            PH_WRITE: begin
                if (!i_mode) begin
                    job_valid     = 1'b1;
                    o_job.kind    = KIND_WRITE;
                    o_job.address = r_addr;
                    o_job.data    = i_word;
                    if (done_inc == r_count) begin
                        n_phase = PH_ADDR;
                        n_addr  = '0;
                        n_count = '0;
                        n_done  = '0;
                    end else begin
                        n_addr = r_addr + ADDR_STEP;
                        n_done = done_inc;
                    end
                end
            end
            PH_READ: begin
                if (i_mode) begin
                    job_valid  = 1'b1;
                    o_job.kind = KIND_TX;
                    o_job.data = i_word;
                    if (done_inc == r_count) begin
                        n_phase = PH_ADDR;
                        n_addr  = '0;
                        n_count = '0;
                        n_done  = '0;
                    end else begin
                        o_job.has_second     = 1'b1;
                        o_job.second_address = r_addr;
                        n_addr               = r_addr + ADDR_STEP;
                        n_done               = done_inc;
                    end
                end
            end
            default: begin
                n_phase = PH_ADDR;
                n_addr  = '0;
                n_count = '0;
                n_done  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_ADDR;
            r_addr  <= '0;
            r_count <= '0;
            r_done  <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_addr  <= n_addr;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

endmodule

### rtl/wsb_queue.sv
// ----------------------------------------------------------------------------
// wsb_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module wsb_queue import wsb_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_stat.full      = (r_cnt == CW'(DEPTH));
    assign o_stat.not_empty = (r_cnt != '0);
    assign do_push          = i_push && !o_stat.full;
    assign do_pop           = i_pop && o_stat.not_empty;
    assign o_job            = r_mem[r_rd_ptr];

    function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] ptr);
        logic [AW-1:0] nxt;
        nxt = (ptr == AW'(DEPTH - 1)) ? '0 : ptr + AW'(1);
        return nxt;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### rtl/wsb_back.sv
// ----------------------------------------------------------------------------
// wsb_back
// expands queued jobs into bus and link results through an output register
// ----------------------------------------------------------------------------
module wsb_back import wsb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_job,
    input  t_q_stat     i_q_stat,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [31:0] o_address,
    output logic [31:0] o_data,
    output logic        o_last
);

    logic        r_valid;
    logic        r_sec_pend;
    logic [31:0] r_sec_addr;
    logic [1:0]  r_kind;
    logic [31:0] r_address;
    logic [31:0] r_data;
    logic        r_last;
    logic        load;

    assign load  = !r_valid || i_ready;
    assign o_pop = load && !r_sec_pend && i_q_stat.not_empty;

    assign o_valid   = r_valid;
    assign o_kind    = r_kind;
    assign o_address = r_address;
    assign o_data    = r_data;
    assign o_last    = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_sec_pend <= 1'b0;
        end else if (load) begin
            if (r_sec_pend) begin
                r_valid    <= 1'b1;
                r_sec_pend <= 1'b0;
            end else begin
                r_valid    <= i_q_stat.not_empty;
                r_sec_pend <= i_q_stat.not_empty && i_job.has_second;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_sec_pend) begin
                r_kind    <= KIND_READREQ;
                r_address <= r_sec_addr;
                r_data    <= '0;
                r_last    <= 1'b1;
            end else begin
                r_kind     <= i_job.kind;
                r_address  <= i_job.address;
                r_data     <= i_job.data;
                r_last     <= !i_job.has_second;
                r_sec_addr <= i_job.second_address;
            end
        end
    end

endmodule

### rtl/word_stream_bus_bridge_unit.sv
// ----------------------------------------------------------------------------
// word_stream_bus_bridge_unit
// serial link to bus command engine: address word, control word, then
// write data or read returns; results go out as bus writes, read requests,
// words to transmit or bad-command reports
// ----------------------------------------------------------------------------
// channel   direction  handshake           payload
// input     in         i_valid / o_ready   i_mode, i_word
// result    out        o_valid / i_ready   o_kind, o_address, o_data, o_last
//
// one input transaction per cycle while the job queue has room
// results leave one per cycle while the receiver is ready; a read return with
// more words to come gives a word to transmit, then the next read request
// the first result passes through the queue and then the output register
// before it shows on the result channel
// synchronous reset returns to waiting for the address word and empties
// the queue; a stalled output fills the queue, then input ready drops
module word_stream_bus_bridge_unit import wsb_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [31:0] i_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [31:0] o_address,
    output logic [31:0] o_data,
    output logic        o_last
);

    t_job    push_job;
    t_job    head_job;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    wsb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_mode   (i_mode),
        .i_word   (i_word),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_job    (push_job)
    );

    wsb_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    wsb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (head_job),
        .i_q_stat  (q_stat),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_kind    (o_kind),
        .o_address (o_address),
        .o_data    (o_data),
        .o_last    (o_last)
    );

endmodule

### rtl/wsb_checker.sv
// ----------------------------------------------------------------------------
// wsb_port_checker
// port-level assertions on the bridge result channel
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsb_port_checker import wsb_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_kind,
    input logic [31:0] o_address,
    input logic [31:0] o_data,
    input logic        o_last
);

    logic out_stall;
    logic bad_shown;
    logic tx_shown;
    logic nodata_shown;
    logic tx_split_taken;

    assign out_stall      = o_valid && !i_ready;
    assign bad_shown      = o_valid && (o_kind == KIND_BAD);
    assign tx_shown       = o_valid && (o_kind == KIND_TX);
    assign nodata_shown   = o_valid && (o_kind == KIND_READREQ || o_kind == KIND_BAD);
    assign tx_split_taken = o_valid && i_ready && (o_kind == KIND_TX) && !o_last;

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_valid && $stable(o_data))
    `ASSERT_SAME(a_bad_clean, i_clk, i_rst_n, bad_shown, ((o_address | o_data) == 32'd0) && o_last)
    `ASSERT_SAME(a_tx_no_addr, i_clk, i_rst_n, tx_shown, o_address == 32'd0)
    `ASSERT_SAME(a_req_no_data, i_clk, i_rst_n, nodata_shown, o_data == 32'd0)
    `ASSERT_NEXT(a_tx_then_req, i_clk, i_rst_n, tx_split_taken, o_valid && o_kind == KIND_READREQ && o_last)

endmodule

bind word_stream_bus_bridge_unit wsb_port_checker u_wsb_checker (.*);

### tb/wsb_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wsb_checker
// watches both channels of the word stream bus bridge, follows the link
// protocol (address word, control word, write data or read returns) in its
// own copy of the engine state, queues the results that each accepted input
// transaction should cause, and compares every output transaction with the
// oldest one queued
// ----------------------------------------------------------------------------
module wsb_checker import wsb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_mode,
    input  logic [31:0] i_word,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_address,
    input  logic [31:0] i_data,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [31:0] data;
        logic        last;
    } t_bus_result;

    t_bus_result expected_results[$];
    t_phase      link_phase;
    logic [31:0] cur_address;
    logic [15:0] xfer_count;
    logic [15:0] xfer_done;
    int          fail_total;

    initial begin
        fail_total = 0;
    end

    function automatic void bridge_idle();
        link_phase  = PH_ADDR;
        cur_address = '0;
        xfer_count  = '0;
        xfer_done   = '0;
    endfunction

    function automatic void queue_result(input logic [1:0] kind, input logic [31:0] address,
                                         input logic [31:0] data, input logic last);
        t_bus_result res;
        res.kind    = kind;
        res.address = address;
        res.data    = data;
        res.last    = last;
        expected_results.push_back(res);
    endfunction

    function automatic void predict_bridge(input logic mode, input logic [31:0] word);
        logic [15:0] cmd;
        logic [15:0] cnt;
        cmd = word[31:16];
        cnt = word[15:0];
        case (link_phase)
            PH_ADDR: begin
                if (!mode) begin
                    cur_address = word;
                    link_phase  = PH_CTRL;
                end
            end
            PH_CTRL: begin
                if (!mode) begin
                    if (cnt == '0) begin
                        bridge_idle();
                    end else if (cmd == CMD_WRITE) begin
                        xfer_count = cnt;
                        xfer_done  = '0;
                        link_phase = PH_WRITE;
                    end else if (cmd == CMD_READ) begin
                        xfer_count = cnt;
                        xfer_done  = '0;
                        link_phase = PH_READ;
                        queue_result(KIND_READREQ, cur_address, '0, 1'b1);
                        cur_address = cur_address + ADDR_STEP;
                    end else begin
                        bridge_idle();
                        queue_result(KIND_BAD, '0, '0, 1'b1);
                    end
                end
            end
            PH_WRITE: begin
                if (!mode) begin
                    queue_result(KIND_WRITE, cur_address, word, 1'b1);
                    cur_address = cur_address + ADDR_STEP;
                    xfer_done   = xfer_done + 16'd1;
                    if (xfer_done == xfer_count) bridge_idle();
                end
            end
            default: begin
                if (mode) begin
                    xfer_done = xfer_done + 16'd1;
                    if (xfer_done == xfer_count) begin
                        bridge_idle();
                        queue_result(KIND_TX, '0, word, 1'b1);
                    end else begin
                        queue_result(KIND_TX, '0, word, 1'b0);
                        queue_result(KIND_READREQ, cur_address, '0, 1'b1);
                        cur_address = cur_address + ADDR_STEP;
                    end
                end
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_bus_result want;
        if (!i_rst_n) begin
            bridge_idle();
            expected_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) predict_bridge(i_mode, i_word);
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with none expected: kind %0d address %h data %h",
                           i_kind, i_address, i_data);
                    fail_total++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_kind !== want.kind) begin
                        $error("kind: expected %0d, actual %0d", want.kind, i_kind);
                        fail_total++;
                    end
                    if (i_address !== want.address) begin
                        $error("address: expected %h, actual %h", want.address, i_address);
                        fail_total++;
                    end
                    if (i_data !== want.data) begin
                        $error("data: expected %h, actual %h", want.data, i_data);
                        fail_total++;
                    end
                    if (i_last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, i_last);
                        fail_total++;
                    end
                end
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fail_total;
    end

endmodule

### tb/tb_word_stream_bus_bridge_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_word_stream_bus_bridge_unit
// drives link words and bus read returns into the bridge: a directed set of
// corner cases, then random write, read, zero-count and bad-command
// transactions with stray words and noise, under bursty input and a stalling
// receiver with long hold-offs; the checker predicts and compares results
// ----------------------------------------------------------------------------
module tb_word_stream_bus_bridge_unit;
    import wsb_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_mode;
    logic [31:0] i_word;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_kind;
    logic [31:0] o_address;
    logic [31:0] o_data;
    logic        o_last;

    int fail_count;
    int pending;
    int burst_left = 0;
    int item_total = 0;

    word_stream_bus_bridge_unit u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_mode    (i_mode),
        .i_word    (i_word),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_kind    (o_kind),
        .o_address (o_address),
        .o_data    (o_data),
        .o_last    (o_last)
    );

    wsb_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_mode       (i_mode),
        .i_word       (i_word),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_kind       (o_kind),
        .i_address    (o_address),
        .i_data       (o_data),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

    // one input transaction, with bursts and gaps
    task automatic push_word(input logic mode, input logic [31:0] word);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        item_total++;
        i_valid <= 1'b1;
        i_mode  <= mode;
        i_word  <= word;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // wrong-kind word for the current phase, now and then
    task automatic stray_word(input logic mode);
        if ($urandom_range(0, 9) == 0) push_word(mode, $urandom);
    endtask

    task automatic send_header(input logic [31:0] base, input logic [31:0] ctrl);
        stray_word(1'b1);
        push_word(1'b0, base);
        stray_word(1'b1);
        push_word(1'b0, ctrl);
    endtask

    // receiver stall patterns, with a long hold-off now and then
    initial begin
        int pattern;
        int stretch_no;
        i_ready    = 1'b0;
        stretch_no = 0;
        forever begin
            pattern = $urandom_range(0, 3);
            repeat ($urandom_range(20, 200)) begin
                @(negedge i_clk);
                case (pattern)
                    0: i_ready <= 1'b1;
                    1: i_ready <= ($urandom_range(0, 9) < 7);
                    2: i_ready <= ($urandom_range(0, 9) < 3);
                    default: i_ready <= ~i_ready;
                endcase
            end
            stretch_no++;
            if (stretch_no % 10 == 4) begin
                @(negedge i_clk);
                i_ready <= 1'b0;
                repeat (300) @(negedge i_clk);
            end
        end
    end

    initial begin
        logic [31:0] base;
        logic [15:0] cmd;
        int          n;
        int          pick;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_mode  = 1'b0;
        i_word  = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // bus return while idle is dropped
        push_word(1'b1, 32'hFFFF_FFFF);
        // write across the top of the address space, stray returns in between
        push_word(1'b0, 32'hFFFF_FFF8);
        push_word(1'b1, 32'h0000_0000);
        push_word(1'b0, {CMD_WRITE, 16'd3});
        push_word(1'b0, 32'hFFFF_FFFF);
        push_word(1'b1, 32'h1234_5678);
        push_word(1'b0, 32'h0000_0000);
        push_word(1'b0, 32'hA5A5_5A5A);
        // zero count with command zero
        push_word(1'b0, 32'h0000_0000);
        push_word(1'b0, 32'h0000_0000);
        // all-ones control word is a bad command
        push_word(1'b0, 32'h1234_5678);
        push_word(1'b0, 32'hFFFF_FFFF);
        // read of two words, link word dropped while reading
        push_word(1'b0, 32'h0000_0010);
        push_word(1'b0, {CMD_READ, 16'd2});
        push_word(1'b0, 32'hDEAD_BEEF);
        push_word(1'b1, 32'hFFFF_FFFF);
        push_word(1'b1, 32'h0000_0000);
        // zero count with read and write commands
        push_word(1'b0, 32'hFFFF_FFFC);
        push_word(1'b0, {CMD_READ, 16'h0000});
        push_word(1'b0, 32'h0000_0004);
        push_word(1'b0, {CMD_WRITE, 16'h0000});
        // command zero with a count is bad
        push_word(1'b0, 32'h8000_0000);
        push_word(1'b0, 32'h0000_0005);

        while (item_total < 900) begin
            pick = $urandom_range(0, 9);
            base = $urandom;
            n    = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            case (pick)
                0, 1, 2, 3: begin
                    send_header(base, {CMD_WRITE, 16'(n)});
                    repeat (n) begin
                        stray_word(1'b1);
                        push_word(1'b0, $urandom);
                    end
                end
                4, 5, 6: begin
                    send_header(base, {CMD_READ, 16'(n)});
                    repeat (n) begin
                        stray_word(1'b0);
                        push_word(1'b1, $urandom);
                    end
                end
                7: send_header(base, {16'($urandom), 16'h0000});
                8: begin
                    cmd = 16'($urandom);
                    if (cmd == CMD_WRITE || cmd == CMD_READ) cmd = 16'h0000;
                    send_header(base, {cmd, 16'(n)});
                end
                default: begin
                    repeat ($urandom_range(1, 3)) begin
                        push_word(1'($urandom_range(0, 1)),
                                  {16'($urandom), 12'h000, 4'($urandom_range(0, 15))});
                    end
                end
            endcase
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/wsb_pkg.sv
rtl/wsb_front.sv
rtl/wsb_queue.sv
rtl/wsb_back.sv
rtl/word_stream_bus_bridge_unit.sv
rtl/wsb_checker.sv
tb/wsb_checker.sv
tb/tb_word_stream_bus_bridge_unit.sv
